/* design/assert_macros.svh */
// Assertion macros shared by the field splat block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vffs_pkg.sv */
// Shared widths, codes, constants and controller/datapath types
// for the vector field falloff splat block. No dependencies.
`timescale 1ns / 1ps

package vffs_pkg;

  // Item field widths.
  localparam int POS_W      = 16;
  localparam int VEL_W      = 16;
  localparam int CELL_W     = 6;
  localparam int FORCE_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int LERP_W     = 17;
  localparam int FRAME_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LERP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd4096;
  localparam logic [LERP_W-1:0]  LERP_RST   = 17'd6554;
  localparam logic [FRAME_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [FRAME_W-1:0] HEIGHT_RST = 12'd480;

  // Item function codes.
  localparam logic FUNC_SPLAT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Falloff radius in Q12.4 units and weight arithmetic.
  localparam int FALLOFF_PIX = 20;
  localparam int LIM         = FALLOFF_PIX * 16;
  localparam int LIM_W       = $clog2(LIM + 1);
  localparam int DIST_W      = POS_W + 1;
  localparam int WEIGHT_W    = 17;
  localparam int WNUM_W      = LIM_W + 16;
  localparam int WSH         = WNUM_W + $clog2(LIM);
  localparam int WMUL_W      = 26;
  // Exact reciprocal of LIM for numerators below 2**WNUM_W.
  localparam logic [WMUL_W-1:0] WMUL =
    WMUL_W'(((64'd1 << WSH) + 64'(LIM) - 64'd1) / 64'(LIM));

  // Blend arithmetic widths.
  localparam int TARGET_W = GAIN_W + 1 + VEL_W - 12;
  localparam int RATE_W   = 17;
  localparam int DIFF_W   = FORCE_W + 1;
  localparam int BPROD_W  = DIFF_W + RATE_W + 1;
  localparam int NEW_W    = BPROD_W - 16;

  localparam logic signed [NEW_W-1:0] NEW_MAX = 27'sd8388607;
  localparam logic signed [NEW_W-1:0] NEW_MIN = -27'sd8388608;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic prep;
    logic sweep_step;
    logic read_issue;
    logic res_load;
  } vffs_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
  } vffs_stat_t;

endpackage

/* design/vffs_if.sv */
// Handshake channel interfaces of the splat block: request items,
// result items and register writes. Depends on vffs_pkg.
`timescale 1ns / 1ps

interface vffs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [vffs_pkg::POS_W-1:0]   point_x;
  logic [vffs_pkg::POS_W-1:0]   point_y;
  logic signed [vffs_pkg::VEL_W-1:0] vel_x;
  logic signed [vffs_pkg::VEL_W-1:0] vel_y;
  logic [vffs_pkg::CELL_W-1:0]  cell_col;
  logic [vffs_pkg::CELL_W-1:0]  cell_row;

  modport source (output valid, func, point_x, point_y, vel_x, vel_y, cell_col, cell_row,
                  input ready);
  modport sink (input valid, func, point_x, point_y, vel_x, vel_y, cell_col, cell_row,
                output ready);
endinterface

interface vffs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [vffs_pkg::FORCE_W-1:0] force_x;
  logic signed [vffs_pkg::FORCE_W-1:0] force_y;
  logic                               saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink (input valid, force_x, force_y, saturated, output ready);
endinterface

interface vffs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vffs_pkg::CFG_IDX_W-1:0]  index;
  logic [vffs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/vffs_datapath.sv */
// Datapath of the splat block: registers, field memories, the per-cell
// update pipeline and the result register. Depends on vffs_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vffs_datapath #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vffs_pkg::vffs_cmd_t                 cmd,
  output vffs_pkg::vffs_stat_t                stat,
  input  logic                                req_func,
  input  logic [vffs_pkg::POS_W-1:0]          req_point_x,
  input  logic [vffs_pkg::POS_W-1:0]          req_point_y,
  input  logic signed [vffs_pkg::VEL_W-1:0]   req_vel_x,
  input  logic signed [vffs_pkg::VEL_W-1:0]   req_vel_y,
  input  logic [vffs_pkg::CELL_W-1:0]         req_cell_col,
  input  logic [vffs_pkg::CELL_W-1:0]         req_cell_row,
  input  logic                                cfg_wr,
  input  logic [vffs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vffs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [vffs_pkg::FORCE_W-1:0] force_x,
  output logic signed [vffs_pkg::FORCE_W-1:0] force_y,
  output logic                                saturated
);

  localparam int CELLS   = GRID_SIZE * GRID_SIZE;
  localparam int AW      = $clog2(CELLS);
  localparam int RW      = $clog2(GRID_SIZE);
  localparam int NUM_W   = 24;
  localparam int PSH     = NUM_W + $clog2(GRID_SIZE);
  localparam int PMUL_W  = 26;
  localparam int PPROD_W = NUM_W + PMUL_W;
  localparam int WPROD_W = vffs_pkg::WNUM_W + vffs_pkg::WMUL_W;
  localparam int RPROD_W = vffs_pkg::WEIGHT_W + vffs_pkg::LERP_W;
  localparam int GP_W    = vffs_pkg::GAIN_W + vffs_pkg::VEL_W + 1;
  localparam int FW      = vffs_pkg::FORCE_W;
  localparam int PW      = vffs_pkg::POS_W;
  // Exact reciprocal of GRID_SIZE for numerators below 2**NUM_W.
  localparam logic [PMUL_W-1:0] PMUL =
    PMUL_W'(((64'd1 << PSH) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE));
  localparam logic [8:0] GRID_L = 9'(GRID_SIZE);

  // Configuration registers.
  logic [vffs_pkg::GAIN_W-1:0]  gain;
  logic [vffs_pkg::LERP_W-1:0]  lerp_rate;
  logic [vffs_pkg::FRAME_W-1:0] frame_width;
  logic [vffs_pkg::FRAME_W-1:0] frame_height;

  // Captured item.
  logic                          func_q;
  logic [PW-1:0]                 px_q;
  logic [PW-1:0]                 py_q;
  logic signed [vffs_pkg::VEL_W-1:0] vx_q;
  logic signed [vffs_pkg::VEL_W-1:0] vy_q;
  logic [vffs_pkg::CELL_W-1:0]   col_q;
  logic [vffs_pkg::CELL_W-1:0]   row_q;

  logic signed [vffs_pkg::TARGET_W-1:0] tx;
  logic signed [vffs_pkg::TARGET_W-1:0] ty;
  logic signed [vffs_pkg::GAIN_W+vffs_pkg::VEL_W:0] gx_prod;
  logic signed [vffs_pkg::GAIN_W+vffs_pkg::VEL_W:0] gy_prod;
  logic sat_acc;

  // Sweep counters.
  logic [AW-1:0]    addr;
  logic [RW-1:0]    row;
  logic [NUM_W-1:0] numx;
  logic [NUM_W-1:0] numy;

  // Memories and ports.
  logic [FW-1:0] mem_x [CELLS];
  logic [FW-1:0] mem_y [CELLS];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [FW-1:0] wr_x;
  logic [FW-1:0] wr_y;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [FW-1:0] rd_x;
  logic [FW-1:0] rd_y;
  logic [15:0]   item_addr;
  logic          item_inside;

  // Pipeline stages.
  logic              s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic [NUM_W-1:0]  s1_numx, s1_numy;
  logic [AW-1:0]     s1_addr, s2_addr, s3_addr, s4_addr, s5_addr, s6_addr;
  logic [PW-1:0]     s2_cx, s2_cy;
  logic [FW-1:0]     s2_oldx, s2_oldy, s3_oldx, s3_oldy, s4_oldx, s4_oldy;
  logic [FW-1:0]     s5_oldx, s5_oldy, s6_oldx, s6_oldy;
  logic [vffs_pkg::LIM_W-1:0]    s3_limd;
  logic [vffs_pkg::WEIGHT_W-1:0] s4_w;
  logic [vffs_pkg::RATE_W-1:0]   s5_rate;
  logic signed [vffs_pkg::BPROD_W-1:0] s6_prodx, s6_prody;

  logic [PPROD_W-1:0] cx_prod, cy_prod;
  logic [PW:0]        dx, dy, ax, ay;
  logic [vffs_pkg::DIST_W-1:0] mdist, limd_full;
  logic               in_range;
  logic [WPROD_W-1:0] w_prod;
  logic [RPROD_W-1:0] r_prod;
  logic signed [vffs_pkg::DIFF_W-1:0]  diffx, diffy;
  logic signed [vffs_pkg::RATE_W:0]    rate_s;
  logic signed [vffs_pkg::NEW_W-1:0]   nx, ny;
  logic signed [FW-1:0] clip_x, clip_y;
  logic                 sat_x, sat_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= vffs_pkg::GAIN_RST;
      lerp_rate    <= vffs_pkg::LERP_RST;
      frame_width  <= vffs_pkg::WIDTH_RST;
      frame_height <= vffs_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        vffs_pkg::CFG_GAIN:   gain         <= cfg_data[vffs_pkg::GAIN_W-1:0];
        vffs_pkg::CFG_LERP:   lerp_rate    <= cfg_data[vffs_pkg::LERP_W-1:0];
        vffs_pkg::CFG_WIDTH:  frame_width  <= cfg_data[vffs_pkg::FRAME_W-1:0];
        vffs_pkg::CFG_HEIGHT: frame_height <= cfg_data[vffs_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q <= req_func;
      px_q   <= req_point_x;
      py_q   <= req_point_y;
      vx_q   <= req_vel_x;
      vy_q   <= req_vel_y;
      col_q  <= req_cell_col;
      row_q  <= req_cell_row;
    end
  end

  // Target force: gain times velocity, the upper bits give the floor.
  assign gx_prod = GP_W'($signed({1'b0, gain})) * GP_W'(vx_q);
  assign gy_prod = GP_W'($signed({1'b0, gain})) * GP_W'(vy_q);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      tx <= gx_prod[vffs_pkg::GAIN_W+vffs_pkg::VEL_W:12];
      ty <= gy_prod[vffs_pkg::GAIN_W+vffs_pkg::VEL_W:12];
    end
  end

  // Row is the inner loop, so the cell address simply counts up.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      row  <= '0;
    end else if (cmd.prep) begin
      addr <= '0;
      row  <= '0;
      numx <= '0;
      numy <= '0;
    end else if (cmd.clear_step) begin
      addr <= addr + AW'(1);
    end else if (cmd.sweep_step) begin
      addr <= addr + AW'(1);
      if (row == RW'(GRID_SIZE - 1)) begin
        row  <= '0;
        numy <= '0;
        numx <= numx + NUM_W'({frame_width, 4'b0});
      end else begin
        row  <= row + RW'(1);
        numy <= numy + NUM_W'({frame_height, 4'b0});
      end
    end
  end

  assign stat.cnt_last  = (addr == AW'(CELLS - 1));
  assign stat.pipe_busy = s1_v | s2_v | s3_v | s4_v | s5_v | s6_v;

  // Read item address and range check.
  assign item_addr   = (16'(col_q) * 16'(GRID_SIZE)) + 16'(row_q);
  assign item_inside = ({3'b0, col_q} < GRID_L) && ({3'b0, row_q} < GRID_L);

  assign rd_en   = cmd.sweep_step | cmd.read_issue;
  assign rd_addr = cmd.read_issue ? item_addr[AW-1:0] : addr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  assign wr_en   = cmd.clear_step | s6_v;
  assign wr_addr = cmd.clear_step ? addr : s6_addr;
  assign wr_x    = cmd.clear_step ? '0 : clip_x;
  assign wr_y    = cmd.clear_step ? '0 : clip_y;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // Stage 1: cell screen position by reciprocal multiply.
  assign cx_prod = PPROD_W'(s1_numx) * PPROD_W'(PMUL);
  assign cy_prod = PPROD_W'(s1_numy) * PPROD_W'(PMUL);

  // Stage 2: Manhattan distance and falloff test.
  assign dx        = {1'b0, s2_cx} - {1'b0, px_q};
  assign dy        = {1'b0, s2_cy} - {1'b0, py_q};
  assign ax        = dx[PW] ? ((PW+1)'(0) - dx) : dx;
  assign ay        = dy[PW] ? ((PW+1)'(0) - dy) : dy;
  assign mdist     = {1'b0, ax[PW-1:0]} + {1'b0, ay[PW-1:0]};
  assign in_range  = mdist < vffs_pkg::DIST_W'(vffs_pkg::LIM);
  assign limd_full = vffs_pkg::DIST_W'(vffs_pkg::LIM) - mdist;

  // Stage 3: weight = (LIM - d) * 65536 / LIM.
  assign w_prod = WPROD_W'({s3_limd, 16'b0}) * WPROD_W'(vffs_pkg::WMUL);

  // Stage 4: effective rate.
  assign r_prod = RPROD_W'(s4_w) * RPROD_W'(lerp_rate);

  // Stage 5: blend product.
  assign rate_s = $signed({1'b0, s5_rate});
  assign diffx  = vffs_pkg::DIFF_W'(tx) - vffs_pkg::DIFF_W'($signed(s5_oldx));
  assign diffy  = vffs_pkg::DIFF_W'(ty) - vffs_pkg::DIFF_W'($signed(s5_oldy));

  // Stage 6: add, clip and write back.
  assign nx = vffs_pkg::NEW_W'($signed(s6_oldx)) + s6_prodx[vffs_pkg::BPROD_W-1:16];
  assign ny = vffs_pkg::NEW_W'($signed(s6_oldy)) + s6_prody[vffs_pkg::BPROD_W-1:16];

  always_comb begin
    sat_x  = 1'b0;
    sat_y  = 1'b0;
    clip_x = nx[FW-1:0];
    clip_y = ny[FW-1:0];
    if (nx > vffs_pkg::NEW_MAX) begin
      clip_x = vffs_pkg::NEW_MAX[FW-1:0];
      sat_x  = 1'b1;
    end else if (nx < vffs_pkg::NEW_MIN) begin
      clip_x = vffs_pkg::NEW_MIN[FW-1:0];
      sat_x  = 1'b1;
    end
    if (ny > vffs_pkg::NEW_MAX) begin
      clip_y = vffs_pkg::NEW_MAX[FW-1:0];
      sat_y  = 1'b1;
    end else if (ny < vffs_pkg::NEW_MIN) begin
      clip_y = vffs_pkg::NEW_MIN[FW-1:0];
      sat_y  = 1'b1;
    end
  end

  // Stage valid bits; cells outside the falloff radius leave after stage 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      s1_v <= cmd.sweep_step;
      s2_v <= s1_v;
      s3_v <= s2_v & in_range;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_numx  <= numx;
    s1_numy  <= numy;
    s1_addr  <= addr;
    s2_cx    <= cx_prod[PSH +: PW];
    s2_cy    <= cy_prod[PSH +: PW];
    s2_oldx  <= rd_x;
    s2_oldy  <= rd_y;
    s2_addr  <= s1_addr;
    s3_limd  <= limd_full[vffs_pkg::LIM_W-1:0];
    s3_oldx  <= s2_oldx;
    s3_oldy  <= s2_oldy;
    s3_addr  <= s2_addr;
    s4_w     <= w_prod[vffs_pkg::WSH +: vffs_pkg::WEIGHT_W];
    s4_oldx  <= s3_oldx;
    s4_oldy  <= s3_oldy;
    s4_addr  <= s3_addr;
    s5_rate  <= r_prod[16 +: vffs_pkg::RATE_W];
    s5_oldx  <= s4_oldx;
    s5_oldy  <= s4_oldy;
    s5_addr  <= s4_addr;
    s6_prodx <= vffs_pkg::BPROD_W'(diffx) * vffs_pkg::BPROD_W'(rate_s);
    s6_prody <= vffs_pkg::BPROD_W'(diffy) * vffs_pkg::BPROD_W'(rate_s);
    s6_oldx  <= s5_oldx;
    s6_oldy  <= s5_oldy;
    s6_addr  <= s5_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sat_acc <= 1'b0;
    end else if (s6_v && (sat_x || sat_y)) begin
      sat_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (func_q == vffs_pkg::FUNC_READ) begin
        force_x   <= item_inside ? $signed(rd_x) : '0;
        force_y   <= item_inside ? $signed(rd_y) : '0;
        saturated <= 1'b0;
      end else begin
        force_x   <= '0;
        force_y   <= '0;
        saturated <= sat_acc;
      end
    end
  end

  `VFFS_ASSERT_IMP(a_clear_no_writeback, cmd.clear_step, !s6_v, "clear overlaps a cell write")
  `VFFS_ASSERT_IMP(a_prep_drained, cmd.prep, !stat.pipe_busy, "splat starts over pending writes")

endmodule

/* design/vffs_ctrl.sv */
// Controller of the splat block: sequences the clearing pass, read items,
// splat sweeps and the result handshake. Depends on vffs_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vffs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_func,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vffs_pkg::vffs_cmd_t  cmd,
  input  vffs_pkg::vffs_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.load_item  = accept;
    cmd.prep       = (state == ST_PREP);
    cmd.sweep_step = (state == ST_SWEEP);
    cmd.read_issue = (state == ST_READ);
    cmd.res_load   = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (stat.cnt_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= (in_func == vffs_pkg::FUNC_READ) ? ST_READ : ST_PREP;
          end
        end
        ST_PREP: state <= ST_SWEEP;
        ST_SWEEP: begin
          if (stat.cnt_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: state <= ST_FINISH;
        ST_FINISH: begin
          if (cmd.res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `VFFS_ASSERT_IMP(a_load_free, cmd.res_load, (!out_valid || out_ready), "result overwritten")
  `VFFS_ASSERT_IMP(a_finish_drained, state == ST_FINISH, !stat.pipe_busy, "result before writes")
  `VFFS_ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE, "accepted item not started")

endmodule

/* design/vector_field_falloff_splat.sv */
// Vector field falloff splat: a GRID_SIZE x GRID_SIZE field of Q15.8 force
// vectors updated by point splats and read one cell at a time.
// Channels: req (items: func, point, velocity, cell), rsp (one result per
// item: force_x, force_y, saturated) and cfg (register writes, always ready).
// Every item returns exactly one result. A read item goes through ST_READ,
// which reads the cell, and ST_FINISH, which loads the result register. A
// splat runs ST_PREP, then the sweep, which reads, updates and writes one
// cell per cycle through the single read and single write port of each
// field memory, followed by a six-stage pipeline drain.
// One item is in work at a time. The result sits in an output register, so
// the next item is accepted while an earlier result still waits; that item's
// result is held back until the receiver takes the earlier one.
// After reset a clearing pass writes zero to every cell, during which no
// item is accepted; registers load their defaults at once and take
// writes throughout.
// Depends on vffs_pkg, the channel interfaces, vffs_ctrl and vffs_datapath.
`timescale 1ns / 1ps

module vector_field_falloff_splat #(
  parameter int GRID_SIZE = 64
) (
  input logic       clk,
  input logic       rst,
  vffs_req_if.sink  req,
  vffs_rsp_if.source rsp,
  vffs_cfg_if.sink  cfg
);

  vffs_pkg::vffs_cmd_t  cmd;
  vffs_pkg::vffs_stat_t stat;
  logic                 cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  vffs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vffs_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_func     (req.func),
    .req_point_x  (req.point_x),
    .req_point_y  (req.point_y),
    .req_vel_x    (req.vel_x),
    .req_vel_y    (req.vel_y),
    .req_cell_col (req.cell_col),
    .req_cell_row (req.cell_row),
    .cfg_wr       (cfg_wr),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .force_x      (rsp.force_x),
    .force_y      (rsp.force_y),
    .saturated    (rsp.saturated)
  );

endmodule

/* tb/testbench.sv */
// Self-checking bench for vector_field_falloff_splat: random and directed splat
// and cell read items against a bit-exact model of the force field.
// Depends on vffs_pkg, the vffs channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import vffs_pkg::*;

  localparam int GRID         = 64;
  localparam int QUIET_LIMIT  = 40000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  typedef struct packed {
    logic                    func;
    logic [POS_W-1:0]        point_x;
    logic [POS_W-1:0]        point_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [CELL_W-1:0]       cell_col;
    logic [CELL_W-1:0]       cell_row;
  } splat_req_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      saturated;
  } cell_force_t;

  logic clk;
  logic rst;

  vffs_req_if req_ch ();
  vffs_rsp_if rsp_ch ();
  vffs_cfg_if cfg_ch ();

  vector_field_falloff_splat #(.GRID_SIZE(GRID)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Model copy of the field and of the registers.
  logic signed [FORCE_W-1:0] force_grid_x [GRID*GRID];
  logic signed [FORCE_W-1:0] force_grid_y [GRID*GRID];
  logic [GAIN_W-1:0]  gain_reg   = GAIN_RST;
  logic [LERP_W-1:0]  lerp_reg   = LERP_RST;
  logic [FRAME_W-1:0] width_reg  = WIDTH_RST;
  logic [FRAME_W-1:0] height_reg = HEIGHT_RST;

  splat_req_t  requests_queued [$];
  cell_force_t forces_due [$];
  splat_req_t  in_flight;

  bit gaps_on = 1'b1;
  bit item_held;
  int gap_left;
  int stall_left;
  int quiet_cycles;
  int last_px;
  int last_py;
  int splats_sent;
  int reads_sent;
  int results_seen;
  int clipped_splats;
  int reg_writes;
  int mismatches;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [FORCE_W-1:0] pull_toward(
      input logic signed [FORCE_W-1:0] old, input longint tgt, input longint rate,
      inout bit clipped);
    longint n;
    n = longint'(old) + (((tgt - longint'(old)) * rate) >>> 16);
    if (n > longint'(NEW_MAX)) begin
      clipped = 1'b1;
      return FORCE_W'(NEW_MAX);
    end
    if (n < longint'(NEW_MIN)) begin
      clipped = 1'b1;
      return FORCE_W'(NEW_MIN);
    end
    return FORCE_W'(n);
  endfunction

  // Applies one item to the model field and returns the result it must produce.
  function automatic cell_force_t run_field_update(splat_req_t it);
    cell_force_t res;
    longint tgt_x, tgt_y, px, py, cx, cy, mdist, weight, rate;
    int k;
    bit clipped;
    res = '0;
    clipped = 1'b0;
    if (it.func == FUNC_READ) begin
      k = int'(it.cell_col) * GRID + int'(it.cell_row);
      res.force_x = force_grid_x[k];
      res.force_y = force_grid_y[k];
      return res;
    end
    tgt_x = (longint'(gain_reg) * longint'($signed(it.vel_x))) >>> 12;
    tgt_y = (longint'(gain_reg) * longint'($signed(it.vel_y))) >>> 12;
    px = longint'(it.point_x);
    py = longint'(it.point_y);
    for (int c = 0; c < GRID; c++) begin
      cx = (longint'(c) * longint'(width_reg) * 16) / GRID;
      for (int r = 0; r < GRID; r++) begin
        cy = (longint'(r) * longint'(height_reg) * 16) / GRID;
        mdist = ((cx > px) ? cx - px : px - cx) + ((cy > py) ? cy - py : py - cy);
        if (mdist < LIM) begin
          weight = ((LIM - mdist) * 65536) / LIM;
          rate = (weight * longint'(lerp_reg)) >>> 16;
          k = c * GRID + r;
          force_grid_x[k] = pull_toward(force_grid_x[k], tgt_x, rate, clipped);
          force_grid_y[k] = pull_toward(force_grid_y[k], tgt_y, rate, clipped);
        end
      end
    end
    res.saturated = clipped;
    return res;
  endfunction

  function automatic splat_req_t splat_item(int px, int py, int vx, int vy);
    splat_req_t it;
    it.func     = FUNC_SPLAT;
    it.point_x  = POS_W'(px);
    it.point_y  = POS_W'(py);
    it.vel_x    = VEL_W'(vx);
    it.vel_y    = VEL_W'(vy);
    it.cell_col = CELL_W'($urandom);
    it.cell_row = CELL_W'($urandom);
    return it;
  endfunction

  function automatic splat_req_t read_item(int col, int row);
    splat_req_t it;
    it.func     = FUNC_READ;
    it.point_x  = POS_W'($urandom);
    it.point_y  = POS_W'($urandom);
    it.vel_x    = VEL_W'($urandom);
    it.vel_y    = VEL_W'($urandom);
    it.cell_col = CELL_W'(col);
    it.cell_row = CELL_W'(row);
    return it;
  endfunction

  // Half splats; most reads land on the cells around the latest splat point.
  function automatic splat_req_t next_random_item();
    splat_req_t it;
    int col, row;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 3) == 0)
        it = splat_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        it = splat_item($urandom_range(0, 16 * width_reg), $urandom_range(0, 16 * height_reg),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
      last_px = int'(it.point_x);
      last_py = int'(it.point_y);
    end else if ($urandom_range(0, 4) == 0) begin
      it = read_item($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1));
    end else begin
      col = (width_reg == 0) ? 0 : (last_px * 4) / int'(width_reg);
      row = (height_reg == 0) ? 0 : (last_py * 4) / int'(height_reg);
      col = col + int'($urandom_range(0, 2)) - 1;
      row = row + int'($urandom_range(0, 2)) - 1;
      col = (col < 0) ? 0 : ((col > GRID - 1) ? GRID - 1 : col);
      row = (row < 0) ? 0 : ((row > GRID - 1) ? GRID - 1 : row);
      it = read_item(col, row);
    end
    return it;
  endfunction

  task automatic queue_random(int count);
    repeat (count) requests_queued.push_back(next_random_item());
  endtask

  // The driver's own held flag changes in the same step as the queues, so this
  // check never sees an item between the queue and the channel.
  task automatic wait_drained();
    while (requests_queued.size() != 0 || item_held || forces_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int gain, int lerp, int fw, int fh);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_LERP, lerp);
    write_reg(CFG_WIDTH, fw);
    write_reg(CFG_HEIGHT, fh);
  endtask

  function automatic void compare_field(string label, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: takes the next item from the queue once the last one is gone.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
      item_held = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        forces_due.push_back(run_field_update(in_flight));
        item_held = 1'b0;
        if (in_flight.func == FUNC_SPLAT) splats_sent++;
        else reads_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (requests_queued.size() > 0) begin
          in_flight = requests_queued.pop_front();
          item_held = 1'b1;
          req_ch.valid    <= 1'b1;
          req_ch.func     <= in_flight.func;
          req_ch.point_x  <= in_flight.point_x;
          req_ch.point_y  <= in_flight.point_y;
          req_ch.vel_x    <= in_flight.vel_x;
          req_ch.vel_y    <= in_flight.vel_y;
          req_ch.cell_col <= in_flight.cell_col;
          req_ch.cell_row <= in_flight.cell_row;
          if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls.
  always @(posedge clk) begin
    cell_force_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (rsp_ch.saturated) clipped_splats++;
        if (forces_due.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, expected none, got %0d %0d %0d",
                   $time, rsp_ch.force_x, rsp_ch.force_y, rsp_ch.saturated);
          mismatches++;
        end else begin
          want = forces_due.pop_front();
          compare_field("force_x", $signed(want.force_x), $signed(rsp_ch.force_x));
          compare_field("force_y", $signed(want.force_y), $signed(rsp_ch.force_y));
          compare_field("saturated", want.saturated, rsp_ch.saturated);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      reg_writes++;
      case (cfg_ch.index)
        CFG_GAIN:   gain_reg   = cfg_ch.data[GAIN_W-1:0];
        CFG_LERP:   lerp_reg   = cfg_ch.data[LERP_W-1:0];
        CFG_WIDTH:  width_reg  = cfg_ch.data[FRAME_W-1:0];
        CFG_HEIGHT: height_reg = cfg_ch.data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // The clearing pass after reset and each splat sweep are the longest quiet spells.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no handshake", quiet_cycles);
      $display("vector_field_falloff_splat verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_SPLAT;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.vel_x = '0;
    req_ch.vel_y = '0;
    req_ch.cell_col = '0;
    req_ch.cell_row = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    foreach (force_grid_x[i]) begin
      force_grid_x[i] = '0;
      force_grid_y[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: empty field, extreme velocities, the falloff edge
    // two columns away, a point far off screen and a point right on a cell.
    requests_queued.push_back(read_item(0, 0));
    requests_queued.push_back(read_item(GRID - 1, GRID - 1));
    requests_queued.push_back(splat_item(0, 0, 32767, -32768));
    requests_queued.push_back(read_item(0, 0));
    requests_queued.push_back(read_item(1, 0));
    requests_queued.push_back(read_item(0, 1));
    requests_queued.push_back(read_item(2, 0));
    requests_queued.push_back(splat_item(65535, 65535, -1, 1));
    requests_queued.push_back(splat_item(800, 600, 256, -256));
    requests_queued.push_back(read_item(5, 5));
    wait_drained();

    // Blend rate near two overshoots; alternating targets drive the cell into the clip.
    set_regs(65535, 131071, WIDTH_RST, HEIGHT_RST);
    for (int i = 0; i < 10; i++)
      requests_queued.push_back(splat_item(0, 0, (i % 2 == 0) ? 32767 : -32768,
                                           (i % 2 == 0) ? -32768 : 32767));
    requests_queued.push_back(read_item(0, 0));
    wait_drained();

    // Zero frame puts every cell at the origin; a full-rate pull to zero clears the field.
    set_regs(0, 65536, 0, 0);
    write_reg(CFG_UNUSED, 131071);
    requests_queued.push_back(splat_item(0, 0, -32768, 32767));
    requests_queued.push_back(read_item(GRID - 1, 0));
    wait_drained();

    set_regs(GAIN_RST, LERP_RST, WIDTH_RST, HEIGHT_RST);
    queue_random(30);
    wait_drained();

    // Mid-phase pause until every outstanding result is back.
    set_regs(40960, 65536, 4095, 4095);
    queue_random(15);
    wait_drained();
    queue_random(15);
    wait_drained();

    set_regs($urandom_range(0, 65535), $urandom_range(0, 131071), 1, 1);
    write_reg(CFG_LERP, 0);
    requests_queued.push_back(splat_item(0, 0, 32767, 32767));
    requests_queued.push_back(read_item(0, 0));
    wait_drained();
    write_reg(CFG_LERP, $urandom_range(0, 131071));
    queue_random(28);
    wait_drained();

    gaps_on = 1'b0;
    set_regs($urandom_range(0, 65535), $urandom_range(0, 131071),
             $urandom_range(1, 4095), $urandom_range(1, 4095));
    queue_random(30);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d splats and %0d cell reads over %0d register writes.",
             splats_sent, reads_sent, reg_writes);
    $display("Checked %0d results, %0d of them splats that clipped; %0d mismatches.",
             results_seen, clipped_splats, mismatches);
    if (mismatches == 0 && forces_due.size() == 0) begin
      $display("vector_field_falloff_splat verification clean");
    end else begin
      $display("vector_field_falloff_splat verification failed");
    end
    $finish;
  end

endmodule
